// ===== rtl/core/topl_pkg.sv =====
// ---------------------------------------------------------------------------
// TFTP option list parser package
// Shared types and constants for the option list parser.
// ---------------------------------------------------------------------------
`default_nettype none
package topl_pkg;

  localparam int unsigned MaxOptions = 8;
  localparam int unsigned MaxNameLen = 16;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StNameOpen   = 3'd1;
  localparam logic [2:0] StValueOpen  = 3'd2;
  localparam logic [2:0] StEmptyValue = 3'd3;
  localparam logic [2:0] StDuplicate  = 3'd4;
  localparam logic [2:0] StTooMany    = 3'd5;
  localparam logic [2:0] StNameLong   = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lowered_byte;
    logic       in_value;
    logic       is_nul;
    logic [2:0] option_slot;
    logic       packet_done;
    logic [2:0] status;
    logic [3:0] options_found;
  } out_item_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] low;
    logic       is_nul;
    logic       last;
  } cls_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/topl_front.sv =====
// ---------------------------------------------------------------------------
// Option list parser front end
// Accepts bytes, lowers A-Z and queues classified bytes for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module topl_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire topl_pkg::in_item_t in_item_i,
  output logic                    cls_valid_o,
  input  wire logic               cls_ready_i,
  output topl_pkg::cls_item_t     cls_item_o
);

  topl_pkg::cls_item_t q_mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  topl_pkg::cls_item_t cls;

  always_comb begin
    cls.is_nul = (in_item_i.data_byte == 8'd0);
    cls.last   = in_item_i.final_byte;
    cls.low    = in_item_i.data_byte;
    if (in_item_i.data_byte inside {[8'h41:8'h5A]}) begin
      cls.low = in_item_i.data_byte + 8'd32;
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cls_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cls_valid_o && cls_ready_i;
  assign cls_item_o  = q_mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/topl_back.sv =====
// ---------------------------------------------------------------------------
// Option list parser back end
// Tracks name/value phase, stores names, checks duplicates, latches errors.
// ---------------------------------------------------------------------------
`default_nettype none
module topl_back #(
  parameter int unsigned MaxOptions = topl_pkg::MaxOptions,
  parameter int unsigned MaxNameLen = topl_pkg::MaxNameLen
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cls_valid_i,
  output logic                     cls_ready_o,
  input  wire topl_pkg::cls_item_t cls_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output topl_pkg::out_item_t      out_item_o
);

  localparam int unsigned LenW = $clog2(MaxNameLen + 1);
  localparam int unsigned CntW = $clog2(MaxOptions + 1);
  localparam int unsigned IdxW = (MaxNameLen > 1) ? $clog2(MaxNameLen) : 1;

  logic [7:0]      name_q [MaxNameLen];
  logic [7:0]      names_q [MaxOptions][MaxNameLen];
  logic [LenW-1:0] lens_q [MaxOptions];
  logic            phase_q, seen_q;
  logic [LenW-1:0] len_q;
  logic [CntW-1:0] cnt_q;
  logic [2:0]      err_q;
  logic            phase_d, seen_d;
  logic [LenW-1:0] len_d;
  logic [CntW-1:0] cnt_d;
  logic [2:0]      err_d;
  logic            store_en, wr_name;
  logic [MaxOptions-1:0] hit;
  logic            dup;
  logic            out_v_q;
  topl_pkg::out_item_t out_q, res;
  logic            take;

  assign cls_ready_o = !out_v_q || pop;
  assign take        = cls_valid_i && cls_ready_o;
  assign empty       = !out_v_q;
  assign out_item_o  = out_q;

  always_comb begin
    for (int k = 0; k < MaxOptions; k++) begin
      hit[k] = (k < cnt_q) && (lens_q[k] == len_q);
      for (int j = 0; j < MaxNameLen; j++) begin
        if ((j < len_q) && (names_q[k][j] != name_q[j])) hit[k] = 1'b0;
      end
    end
    dup = |hit;
  end

  always_comb begin
    phase_d  = phase_q;
    seen_d   = seen_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    err_d    = err_q;
    store_en = 1'b0;
    wr_name  = 1'b0;
    if (err_q == topl_pkg::StOk) begin
      if (!phase_q) begin
        if (!cls_item_i.is_nul) begin
          if (len_q >= LenW'(MaxNameLen)) begin
            err_d = topl_pkg::StNameLong;
          end else begin
            wr_name = 1'b1;
            len_d   = len_q + 1'b1;
          end
        end else begin
          phase_d = 1'b1;
          seen_d  = 1'b0;
        end
      end else if (!cls_item_i.is_nul) begin
        seen_d = 1'b1;
      end else begin
        if (!seen_q)                          err_d = topl_pkg::StEmptyValue;
        else if (dup)                         err_d = topl_pkg::StDuplicate;
        else if (cnt_q >= CntW'(MaxOptions))  err_d = topl_pkg::StTooMany;
        else begin
          store_en = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
        phase_d = 1'b0;
        seen_d  = 1'b0;
        len_d   = '0;
      end
    end
    if (cls_item_i.last && err_d == topl_pkg::StOk) begin
      if (phase_d)               err_d = topl_pkg::StValueOpen;
      else if (len_d != '0)      err_d = topl_pkg::StNameOpen;
    end
    res.lowered_byte  = cls_item_i.low;
    res.in_value      = phase_q;
    res.is_nul        = cls_item_i.is_nul;
    res.option_slot   = (32'(cnt_q) > 32'd7) ? 3'd7 : 3'(cnt_q);
    res.packet_done   = cls_item_i.last;
    res.status        = err_d;
    res.options_found = (32'(cnt_d) > 32'd15) ? 4'd15 : 4'(cnt_d);
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
      if (wr_name) name_q[len_q[IdxW-1:0]] <= cls_item_i.low;
      if (store_en) begin
        names_q[cnt_q[$clog2(MaxOptions > 1 ? MaxOptions : 2)-1:0]] <= name_q;
        lens_q[cnt_q[$clog2(MaxOptions > 1 ? MaxOptions : 2)-1:0]]  <= len_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      phase_q <= 1'b0;
      seen_q  <= 1'b0;
      len_q   <= '0;
      cnt_q   <= '0;
      err_q   <= topl_pkg::StOk;
    end else begin
      if (take) begin
        out_v_q <= 1'b1;
        if (cls_item_i.last) begin
          phase_q <= 1'b0;
          seen_q  <= 1'b0;
          len_q   <= '0;
          cnt_q   <= '0;
          err_q   <= topl_pkg::StOk;
        end else begin
          phase_q <= phase_d;
          seen_q  <= seen_d;
          len_q   <= len_d;
          cnt_q   <= cnt_d;
          err_q   <= err_d;
        end
      end else if (pop) begin
        out_v_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tftp_option_list_parser_core.sv =====
// ---------------------------------------------------------------------------
// TFTP option list parser core
// Parses NUL-terminated name/value pairs of an OACK option area.
// ---------------------------------------------------------------------------
// One byte per cycle sustained while results are popped as they arrive. A byte's
// result passes through the front queue and the back end's output register
// before it is on the outputs. The input stalls only when the two-entry front
// queue is full because results are not being taken. The duplicate check
// compares all stored names in parallel, combinationally in the back end.
`default_nettype none
module tftp_option_list_parser_core #(
  parameter int unsigned MaxOptions = topl_pkg::MaxOptions,
  parameter int unsigned MaxNameLen = topl_pkg::MaxNameLen
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire topl_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output topl_pkg::out_item_t      out_item_o
);

  logic                cls_valid, cls_ready;
  topl_pkg::cls_item_t cls_item;

  topl_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_item_i,
    .cls_valid_o(cls_valid), .cls_ready_i(cls_ready), .cls_item_o(cls_item)
  );

  topl_back #(.MaxOptions(MaxOptions), .MaxNameLen(MaxNameLen)) u_back (
    .clk_i, .rst_ni,
    .cls_valid_i(cls_valid), .cls_ready_o(cls_ready), .cls_item_i(cls_item),
    .empty, .pop, .out_item_o
  );

endmodule
`default_nettype wire
